### rtl/id_to_dense_index_map_assert.svh
// Assertion macros for the id_to_dense_index_map RTL, included by idim_slot.
`ifndef ID_TO_DENSE_INDEX_MAP_ASSERT_SVH
`define ID_TO_DENSE_INDEX_MAP_ASSERT_SVH

// Checked only outside reset.
`define IDIM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("id_to_dense_index_map: assertion failed");

// Checked on every edge, reset included.
`define IDIM_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("id_to_dense_index_map: assertion failed");

`endif

### rtl/idim_pkg.sv
// Types and codes shared by the id_to_dense_index_map slot chain.
package idim_pkg;

   localparam int unsigned KEY_W   = 32;
   localparam int unsigned INDEX_W = 8;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_FOUND   = 2'd0,
      ST_NEW     = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // One request travelling down the chain.
   typedef struct packed {
      logic               valid;
      logic               done;
      op_type             operation;
      logic [KEY_W-1:0]   key;
      logic [INDEX_W-1:0] dense_index;
      status_type         status;
   } item_type;

endpackage

### rtl/idim_slot.sv
// One slot of the key chain: holds one stored key and resolves passing requests.
`include "id_to_dense_index_map_assert.svh"

module idim_slot
   import idim_pkg::*;
#(
   parameter int unsigned SLOT = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  item_type in_item,
   output item_type out_item
);

   localparam logic [INDEX_W-1:0] SLOT_INDEX = INDEX_W'(SLOT % 256);

   logic [KEY_W-1:0] key_ff, key_in;
   logic             fill_ff, fill_in;
   item_type         item_ff, item_in;
   logic             hit;
   logic             claim;

   assign hit   = fill_ff && (in_item.key == key_ff);
   assign claim = in_item.valid && !in_item.done && !fill_ff
                  && (in_item.operation == OP_INSERT);

   always_comb begin
      item_in = in_item;
      key_in  = key_ff;
      fill_in = fill_ff;
      if (in_item.valid && !in_item.done) begin
         if (hit) begin
            item_in.done        = 1'b1;
            item_in.dense_index = SLOT_INDEX;
            item_in.status      = ST_FOUND;
         end else if (!fill_ff) begin
            // first empty slot: nothing beyond it is stored yet
            item_in.done = 1'b1;
            if (claim) begin
               item_in.dense_index = SLOT_INDEX;
               item_in.status      = ST_NEW;
               key_in              = in_item.key;
               fill_in             = 1'b1;
            end else begin
               item_in.dense_index = '0;
               item_in.status      = ST_MISSING;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         key_ff              <= key_in;
         item_ff.done        <= item_in.done;
         item_ff.operation   <= item_in.operation;
         item_ff.key         <= item_in.key;
         item_ff.dense_index <= item_in.dense_index;
         item_ff.status      <= item_in.status;
      end
      if (reset) begin
         fill_ff       <= 1'b0;
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         fill_ff       <= fill_in;
         item_ff.valid <= item_in.valid;
      end
   end

   assign out_item = item_ff;

   `IDIM_ASSERT(a_fill_sticky, fill_ff |=> fill_ff)
   `IDIM_ASSERT(a_key_kept, (fill_ff && advance) |=> (key_ff == $past(key_ff)))
   `IDIM_ASSERT(a_claim_stores,
      (advance && claim) |=> (fill_ff && key_ff == $past(in_item.key)))
   `IDIM_ASSERT(a_miss_zero_index,
      (item_ff.valid && item_ff.done && item_ff.status == ST_MISSING) |->
      (item_ff.dense_index == '0))

endmodule

### rtl/id_to_dense_index_map.sv
// Path: each request beat passes the entry reg, the slot chain and the out reg to the response.
// Throughput: one beat per cycle unless rsp_stall holds; requests walk one slot a cycle.
// The whole chain holds while a response waits under rsp_stall; entry reg still takes one beat.
// Reset (synchronous, active high) empties the table and drops all beats in flight.
// Stored keys carry no reset; a slot's fill bit marks it in use.
module id_to_dense_index_map
   import idim_pkg::*;
#(
   parameter int unsigned CAPACITY = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_operation,
   input  logic signed [KEY_W-1:0]   req_key,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic        [INDEX_W-1:0] rsp_dense_index,
   output logic        [1:0]         rsp_status
);

   item_type link [CAPACITY+1];
   item_type entry_ff, entry_in;
   item_type rsp_ff, rsp_in;
   logic     advance;
   logic     entry_load;

   assign advance    = !rsp_ff.valid || !rsp_stall;
   assign entry_load = !entry_ff.valid || advance;
   assign req_stall  = !entry_load;

   always_comb begin
      entry_in             = entry_ff;
      if (entry_load) begin
         entry_in.valid       = req_valid;
         entry_in.done        = 1'b0;
         entry_in.operation   = op_type'(req_operation);
         entry_in.key         = $unsigned(req_key);
         entry_in.dense_index = '0;
         entry_in.status      = ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.done        <= entry_in.done;
      entry_ff.operation   <= entry_in.operation;
      entry_ff.key         <= entry_in.key;
      entry_ff.dense_index <= entry_in.dense_index;
      entry_ff.status      <= entry_in.status;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   assign link[0] = entry_ff;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
      idim_slot #(
         .SLOT (g)
      ) u_slot (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_item  (link[g]),
         .out_item (link[g+1])
      );
   end

   // unresolved at the tail means every slot was full
   always_comb begin
      rsp_in = link[CAPACITY];
      if (!link[CAPACITY].done) begin
         rsp_in.dense_index = '0;
         rsp_in.status      = (link[CAPACITY].operation == OP_LOOKUP) ? ST_MISSING
                                                                      : ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.done        <= rsp_in.done;
         rsp_ff.operation   <= rsp_in.operation;
         rsp_ff.key         <= rsp_in.key;
         rsp_ff.dense_index <= rsp_in.dense_index;
         rsp_ff.status      <= rsp_in.status;
      end
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else if (advance) begin
         rsp_ff.valid <= rsp_in.valid;
      end
   end

   assign rsp_valid       = rsp_ff.valid;
   assign rsp_dense_index = rsp_ff.dense_index;
   assign rsp_status      = rsp_ff.status;

endmodule
